/* hw/rtl/line_follower_pd_steering_unit_defines.svh */
// ----------------------------------------------------------------------------
// Line follower PD steering unit: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOWER_PD_STEERING_UNIT_DEFINES_SVH
`define LINE_FOLLOWER_PD_STEERING_UNIT_DEFINES_SVH

// same-cycle implication
`define LFPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfpd: same-cycle check failed");

// next-cycle implication
`define LFPD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfpd: next-cycle check failed");

`endif

/* hw/rtl/lfpd_pkg.sv */
// ----------------------------------------------------------------------------
// lfpd_pkg
// Types and constants shared by the PD steering unit, its divider and checker.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int unsigned NUM_SENSORS = 7;
  localparam int unsigned IDX_W       = 3;

  // serial divider: |sum| <= 60, count <= 7
  localparam int unsigned DVD_W = 6;
  localparam int unsigned DVS_W = 3;
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  localparam int unsigned ACC_W = 15;

  localparam logic [1:0] LOST_NONE  = 2'd0;
  localparam logic [1:0] LOST_LEFT  = 2'd1;
  localparam logic [1:0] LOST_RIGHT = 2'd2;

  localparam logic signed [6:0] ERR_LOST    = 7'sd40;
  localparam logic signed [6:0] LOST_THRESH = 7'sd20;
  localparam int              ERR_LIMIT   = 40;

  localparam logic signed [15:0] DRIVE_MAX = 16'sd255;

  localparam logic [5:0] PROP_GAIN_RST  = 6'd8;
  localparam logic [5:0] DERIV_GAIN_RST = 6'd4;
  localparam logic [7:0] BASE_SPEED_RST = 8'd128;

  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_DERIV_GAIN = 2'd1;
  localparam logic [1:0] REG_BASE_SPEED = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_stat_t;

  typedef struct packed {
    logic [7:0] mag;
    logic       rev;
  } drive_t;

endpackage

/* hw/rtl/lfpd_serial_div.sv */
// ----------------------------------------------------------------------------
// lfpd_serial_div
// Radix-2 restoring divider, one quotient bit per cycle; divisor never zero.
// ----------------------------------------------------------------------------
module lfpd_serial_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfpd_pkg::div_req_t   req_i,
  output lfpd_pkg::div_stat_t  stat_o
);
  import lfpd_pkg::*;

  logic [DVD_W-1:0] shreg_q, shreg_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic             ge;

  // dividend bits shift out the top while quotient bits shift in below
  always_comb begin
    trial   = {rem_q, shreg_q[DVD_W-1]};
    ge      = trial >= {1'b0, dvs_q};
    shreg_d = shreg_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      shreg_d = req_i.dividend;
      rem_d   = '0;
      dvs_d   = req_i.divisor;
      cnt_d   = CNT_W'(DVD_W);
    end else if (cnt_q != '0) begin
      shreg_d = {shreg_q[DVD_W-2:0], ge};
      rem_d   = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      cnt_d   = cnt_q - CNT_W'(1);
      done_d  = cnt_q == CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.quot = shreg_q;

endmodule

/* hw/rtl/line_follower_pd_steering_unit.sv */
// ----------------------------------------------------------------------------
// line_follower_pd_steering_unit
// PD steering for a seven-sensor line follower, bit-serial datapath.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------
//  in      | in  | in_valid_i / in_stall_o | sensor_bits_i
//  out     | out | out_valid_o/out_stall_i | position_error_o, left/right
//          |     |                         | drive and reverse
//  cfg     | in  | cfg_we_i                | cfg_idx_i, cfg_data_i
//
//  Each word runs a serial sensor scan, a check, the radix-2 divider (only
//  with a sensor active), a prepare step, the shift-add PD multiply and a
//  commit step before the next word is accepted.
//  Reset clears controller state and restores the register defaults.
//  A stalled result is held in the output register; the next word is taken
//  as soon as the result has been moved there.
// ----------------------------------------------------------------------------
module line_follower_pd_steering_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [6:0]        sensor_bits_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [6:0] position_error_o,
  output logic [7:0]        left_drive_o,
  output logic              left_reverse_o,
  output logic [7:0]        right_drive_o,
  output logic              right_reverse_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_data_i
);
  import lfpd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  // weighted offset of one sensor: (idx - 3) * 10, or * 5 while lost
  function automatic logic signed [6:0] tap_weight(logic [IDX_W-1:0] idx, logic lost);
    logic signed [3:0] off;
    logic signed [6:0] o7;
    begin
      off = $signed({1'b0, idx}) - 4'sd3;
      o7  = {{3{off[3]}}, off};
      tap_weight = lost ? (o7 <<< 2) + o7 : (o7 <<< 3) + (o7 <<< 1);
    end
  endfunction

  function automatic drive_t drive_fn(logic signed [15:0] cmd);
    drive_t            r;
    logic signed [15:0] c;
    begin
      if (cmd > DRIVE_MAX)       c = DRIVE_MAX;
      else if (cmd < -DRIVE_MAX) c = -DRIVE_MAX;
      else                       c = cmd;
      r.rev    = c[15];
      r.mag    = c[15] ? 8'(-c) : c[7:0];
      drive_fn = r;
    end
  endfunction

  logic [2:0]             state_q, state_d;
  logic [5:0]             prop_q, prop_d;
  logic [5:0]             deriv_q, deriv_d;
  logic [7:0]             base_q, base_d;
  logic signed [6:0]      last_seen_q, last_seen_d;
  logic [1:0]             lost_q, lost_d;
  logic signed [6:0]      prev_q, prev_d;

  logic [6:0]             bits_q, bits_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic signed [6:0]      sum_q, sum_d;
  logic [DVS_W-1:0]       count_q, count_d;
  logic signed [6:0]      err_q, err_d;
  logic                   found_q, found_d;
  logic signed [ACC_W-1:0] mc_p_q, mc_p_d, mc_d_q, mc_d_d, acc_q, acc_d;
  logic [5:0]             gp_q, gp_d, gd_q, gd_d;
  logic [CNT_W-1:0]       mcnt_q, mcnt_d;

  logic                   out_valid_q, out_valid_d;
  logic signed [6:0]      oerr_q, oerr_d;
  drive_t                 ldrv_q, ldrv_d, rdrv_q, rdrv_d;

  div_req_t               div_req;
  div_stat_t              div_stat;

  logic                   out_free;
  logic signed [7:0]      diff;
  logic [6:0]             quot_x;
  logic [6:0]             sum_abs;
  logic signed [15:0]     cmd_l, cmd_r;
  logic [1:0]             lost_mid;

  lfpd_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign sum_abs  = sum_q[6] ? 7'(-sum_q) : sum_q;
  assign quot_x   = {1'b0, div_stat.quot};
  assign diff     = {err_q[6], err_q} - {prev_q[6], prev_q};
  assign cmd_l    = $signed({8'b0, base_q}) + {acc_q[ACC_W-1], acc_q};
  assign cmd_r    = $signed({8'b0, base_q}) - {acc_q[ACC_W-1], acc_q};

  assign div_req.start    = (state_q == ST_CHK) && (count_q != '0);
  assign div_req.dividend = sum_abs[DVD_W-1:0];
  assign div_req.divisor  = count_q;

  always_comb begin
    state_d     = state_q;
    prop_d      = prop_q;
    deriv_d     = deriv_q;
    base_d      = base_q;
    last_seen_d = last_seen_q;
    lost_d      = lost_q;
    prev_d      = prev_q;
    bits_d      = bits_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    count_d     = count_q;
    err_d       = err_q;
    found_d     = found_q;
    mc_p_d      = mc_p_q;
    mc_d_d      = mc_d_q;
    acc_d       = acc_q;
    gp_d        = gp_q;
    gd_d        = gd_q;
    mcnt_d      = mcnt_q;
    oerr_d      = oerr_q;
    ldrv_d      = ldrv_q;
    rdrv_d      = rdrv_q;
    out_valid_d = out_valid_q && out_stall_i;
    lost_mid    = lost_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN:  prop_d  = cfg_data_i[5:0];
        REG_DERIV_GAIN: deriv_d = cfg_data_i[5:0];
        REG_BASE_SPEED: base_d  = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          bits_d  = sensor_bits_i;
          idx_d   = '0;
          sum_d   = '0;
          count_d = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (bits_q[0]) begin
          sum_d   = sum_q + tap_weight(idx_q, lost_q != LOST_NONE);
          count_d = count_q + DVS_W'(1);
        end
        bits_d = bits_q >> 1;
        idx_d  = idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(NUM_SENSORS - 1)) state_d = ST_CHK;
      end
      ST_CHK: begin
        found_d = count_q != '0;
        if (count_q != '0) begin
          state_d = ST_DIV;
        end else begin
          // line lost: fall back on where it was last seen
          if (last_seen_q < -LOST_THRESH)     err_d = -ERR_LOST;
          else if (last_seen_q > LOST_THRESH) err_d = ERR_LOST;
          else                                err_d = '0;
          state_d = ST_PREP;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          err_d   = sum_q[6] ? 7'(-quot_x) : quot_x;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        mc_p_d  = {{(ACC_W-7){err_q[6]}}, err_q};
        mc_d_d  = {{(ACC_W-8){diff[7]}}, diff};
        gp_d    = prop_q;
        gd_d    = deriv_q;
        acc_d   = '0;
        mcnt_d  = CNT_W'(6);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        acc_d  = acc_q + (gp_q[0] ? mc_p_q : '0) + (gd_q[0] ? mc_d_q : '0);
        mc_p_d = mc_p_q <<< 1;
        mc_d_d = mc_d_q <<< 1;
        gp_d   = gp_q >> 1;
        gd_d   = gd_q >> 1;
        mcnt_d = mcnt_q - CNT_W'(1);
        if (mcnt_q == CNT_W'(1)) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          oerr_d      = err_q;
          ldrv_d      = drive_fn(cmd_l);
          rdrv_d      = drive_fn(cmd_r);
          prev_d      = err_q;
          if (found_q) begin
            last_seen_d = err_q;
          end else if (last_seen_q < -LOST_THRESH) begin
            lost_mid = LOST_LEFT;
          end else if (last_seen_q > LOST_THRESH) begin
            lost_mid = LOST_RIGHT;
          end
          // flag drops once the error is back on the near side
          if (lost_mid == LOST_LEFT && !err_q[6])                     lost_d = LOST_NONE;
          else if (lost_mid == LOST_RIGHT && (err_q[6] || err_q == '0)) lost_d = LOST_NONE;
          else                                                        lost_d = lost_mid;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prop_q      <= PROP_GAIN_RST;
      deriv_q     <= DERIV_GAIN_RST;
      base_q      <= BASE_SPEED_RST;
      last_seen_q <= '0;
      lost_q      <= LOST_NONE;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      mcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      prop_q      <= prop_d;
      deriv_q     <= deriv_d;
      base_q      <= base_d;
      last_seen_q <= last_seen_d;
      lost_q      <= lost_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      mcnt_q      <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q  <= bits_d;
    sum_q   <= sum_d;
    count_q <= count_d;
    err_q   <= err_d;
    found_q <= found_d;
    mc_p_q  <= mc_p_d;
    mc_d_q  <= mc_d_d;
    acc_q   <= acc_d;
    gp_q    <= gp_d;
    gd_q    <= gd_d;
    oerr_q  <= oerr_d;
    ldrv_q  <= ldrv_d;
    rdrv_q  <= rdrv_d;
  end

  assign in_stall_o       = state_q != ST_IDLE;
  assign out_valid_o      = out_valid_q;
  assign position_error_o = oerr_q;
  assign left_drive_o     = ldrv_q.mag;
  assign left_reverse_o   = ldrv_q.rev;
  assign right_drive_o    = rdrv_q.mag;
  assign right_reverse_o  = rdrv_q.rev;

endmodule

/* hw/rtl/lfpd_checker.sv */
// ----------------------------------------------------------------------------
// lfpd_checker
// Port-level checks on the PD steering unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_follower_pd_steering_unit_defines.svh"

module lfpd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic signed [6:0] position_error_o,
  input logic [7:0]        left_drive_o,
  input logic              left_reverse_o,
  input logic [7:0]        right_drive_o,
  input logic              right_reverse_o
);
  import lfpd_pkg::*;

  logic        err_ok;
  logic        rev_ok;
  logic [24:0] out_word;

  assign err_ok = (position_error_o >= -7'(ERR_LIMIT)) &&
                  (position_error_o <= 7'(ERR_LIMIT));
  assign rev_ok = (!left_reverse_o || left_drive_o != 8'd0) &&
                  (!right_reverse_o || right_drive_o != 8'd0);
  assign out_word = {position_error_o, left_drive_o, left_reverse_o,
                     right_drive_o, right_reverse_o};

  // the error never leaves the lost-line limits
  `LFPD_ASSERT_IMP(a_err_range, out_valid_o, err_ok)

  // reverse is only flagged for a non-zero command
  `LFPD_ASSERT_IMP(a_rev_nonzero, out_valid_o, rev_ok)

  // one word at a time: an accepted word blocks the input on the next cycle
  `LFPD_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  `LFPD_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word))

endmodule

bind line_follower_pd_steering_unit lfpd_checker u_lfpd_checker (.*);
